@@ sv/pf_pkg.sv @@
// Shared types, constants and helper functions for the Playfair digraph cipher.
package pf_pkg;

   localparam int unsigned SQ_SIDE     = 5;
   localparam int unsigned SQ_CELLS    = 25;
   localparam int unsigned NUM_LETTERS = 26;

   typedef logic [4:0] letter_type;
   typedef logic [4:0] cell_type;
   typedef logic [2:0] coord_type;
   typedef logic [NUM_LETTERS-1:0] letter_set_type;

   localparam letter_type LTR_I   = 5'd8;
   localparam letter_type LTR_J   = 5'd9;
   localparam letter_type LTR_X   = 5'd23;
   localparam letter_type LTR_MAX = 5'd25;
   localparam cell_type   CELLS_FULL = 5'd25;
   localparam coord_type  COORD_MAX  = 3'd4;

   localparam letter_set_type USED_RESET = letter_set_type'(1) << LTR_J;

   typedef enum logic [2:0] {
      CMD_CLEAR   = 3'd0,
      CMD_KEY     = 3'd1,
      CMD_FINISH  = 3'd2,
      CMD_ENCRYPT = 3'd3,
      CMD_DECRYPT = 3'd4,
      CMD_END     = 3'd5
   } cmd_type;

   // Control of the key square store and the reverse letter store.
   typedef struct packed {
      logic       wr_en;
      cell_type   wr_cell;
      letter_type wr_letter;
      letter_type cell_rd_letter;
      cell_type   key_rd_cell;
   } mem_req_type;

   // Bring a cell number into range 0 to 24.
   function automatic cell_type cell_wrap(input cell_type cell_num);
      cell_wrap = (cell_num >= CELLS_FULL) ? 5'(cell_num - CELLS_FULL) : cell_num;
   endfunction

   function automatic coord_type cell_row(input cell_type cell_num);
      cell_type v;
      v = cell_wrap(cell_num);
      if (v >= 5'd20)      cell_row = 3'd4;
      else if (v >= 5'd15) cell_row = 3'd3;
      else if (v >= 5'd10) cell_row = 3'd2;
      else if (v >= 5'd5)  cell_row = 3'd1;
      else                 cell_row = 3'd0;
   endfunction

   function automatic coord_type cell_col(input cell_type cell_num);
      cell_type v;
      coord_type row;
      v = cell_wrap(cell_num);
      row = cell_row(cell_num);
      cell_col = 3'(v - {row, 2'b00} - {2'b00, row});
   endfunction

   function automatic cell_type cell_addr(input coord_type row, input coord_type col);
      cell_addr = {row, 2'b00} + {2'b00, row} + {2'b00, col};
   endfunction

   // One place along a row or column, wrapping round the square.
   function automatic coord_type coord_step(input coord_type v, input logic dec);
      if (dec) coord_step = (v == 3'd0) ? COORD_MAX : 3'(v - 3'd1);
      else     coord_step = (v == COORD_MAX) ? 3'd0 : 3'(v + 3'd1);
   endfunction

endpackage

@@ sv/playfair_digraph_cipher.sv @@
// Top level of the Playfair digraph cipher: command sequencer, pairing state and result register.
//
// Usage. Commands arrive on the req_ channel (valid/ready); each transfer carries a command
// and a letter code A=0 to Z=25. Clear key, key letter and finish key build the 5x5 square;
// encrypt letter, decrypt letter and end message form letter pairs. Each completed pair
// gives two transfers on the rsp_ channel, the second marked by rsp_last.
// Timing. Clear, key letter and any command that completes no pair are done at their
// transfer. Finish key sweeps the alphabet one letter a cycle. A command that completes a
// pair steps through the lookup states: the single read port of the reverse store is used
// twice, the pair rules are applied once, and the single read port of the key square is
// used twice. The first letter of a pair is loaded after the second key read, and the
// second once the first is taken.
// The block takes one command at a time; req_ready is low while a command is at work.
// Stalls. If rsp_ready is held low the letter on display holds and the sequencer waits; once
// the second letter of a pair is loaded the block takes new commands even while it waits.
// Reset. Reset clears the used-letter set to J alone, the fill count and any waiting letter,
// and empties the result register. The square stores keep whatever they held.
module playfair_digraph_cipher (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_command,
   input  pf_pkg::letter_type req_letter,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output pf_pkg::letter_type rsp_out_letter,
   output logic               rsp_last
);
   import pf_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FILL,
      ST_LOOK_A,
      ST_LOOK_B,
      ST_CALC,
      ST_READ_1,
      ST_READ_2,
      ST_EMIT_1,
      ST_EMIT_2
   } state_type;

   state_type      state_ff;
   letter_set_type used_ff;
   cell_type       fill_ff;
   letter_type     sweep_ff;
   letter_type     held_ff;
   logic           held_valid_ff;
   logic           held_dec_ff;
   letter_type     pair_a_ff;
   letter_type     pair_b_ff;
   logic           pair_dec_ff;
   cell_type       cell_a_ff;
   cell_type       addr_a_ff;
   cell_type       addr_b_ff;
   letter_type     first_ff;
   logic           rsp_valid_ff;
   letter_type     rsp_letter_ff;
   logic           rsp_last_ff;

   mem_req_type    mem_req;
   cell_type       cell_rd_ff;
   letter_type     key_rd_ff;
   cell_type       addr_a_in;
   cell_type       addr_b_in;

   logic           accept;
   logic           letter_ok;
   letter_type     letter_norm;
   logic           rsp_free;
   logic           not_full;

   assign req_ready      = (state_ff == ST_IDLE);
   assign accept         = req_valid && req_ready;
   assign letter_ok      = (req_letter <= LTR_MAX);
   // J shares the cell of I throughout.
   assign letter_norm    = (req_letter == LTR_J) ? LTR_I : req_letter;
   assign rsp_free       = !rsp_valid_ff || rsp_ready;
   assign not_full       = (fill_ff < CELLS_FULL);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_letter = rsp_letter_ff;
   assign rsp_last       = rsp_last_ff;

   // Store control: key letters are written at transfer, the finish sweep takes one letter a
   // cycle and writes it if unused, and the read ports follow the pair lookup sequence.
   always_comb begin
      mem_req.wr_en          = 1'b0;
      mem_req.wr_cell        = fill_ff;
      mem_req.wr_letter      = letter_norm;
      mem_req.cell_rd_letter = (state_ff == ST_LOOK_B) ? pair_b_ff : pair_a_ff;
      mem_req.key_rd_cell    = (state_ff == ST_READ_1) ? addr_a_ff : addr_b_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (cmd_type'(req_command) == CMD_KEY) && letter_ok &&
                !used_ff[letter_norm] && not_full) begin
               mem_req.wr_en = 1'b1;
            end
         end
         ST_FILL: begin
            mem_req.wr_letter = sweep_ff;
            mem_req.wr_en     = !used_ff[sweep_ff] && not_full;
         end
         default: begin
         end
      endcase
   end

   pf_square u_square (
      .clock      (clock),
      .mem_req    (mem_req),
      .cell_rd_ff (cell_rd_ff),
      .key_rd_ff  (key_rd_ff)
   );

   pf_pair_calc u_pair_calc (
      .cell_a (cell_a_ff),
      .cell_b (cell_rd_ff),
      .dec    (pair_dec_ff),
      .addr_a (addr_a_in),
      .addr_b (addr_b_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         used_ff       <= USED_RESET;
         fill_ff       <= '0;
         sweep_ff      <= '0;
         held_ff       <= '0;
         held_valid_ff <= 1'b0;
         held_dec_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         // In the emit states a letter that is taken is replaced in the same cycle.
         if (rsp_valid_ff && rsp_ready && (state_ff != ST_EMIT_1) &&
             (state_ff != ST_EMIT_2)) begin
            rsp_valid_ff <= 1'b0;
         end
         if (mem_req.wr_en) begin
            used_ff[mem_req.wr_letter] <= 1'b1;
            fill_ff                    <= 5'(fill_ff + 5'd1);
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  case (cmd_type'(req_command))
                     CMD_CLEAR: begin
                        used_ff       <= USED_RESET;
                        fill_ff       <= '0;
                        held_valid_ff <= 1'b0;
                        held_dec_ff   <= 1'b0;
                     end
                     CMD_FINISH: begin
                        sweep_ff <= '0;
                        state_ff <= ST_FILL;
                     end
                     CMD_ENCRYPT: begin
                        if (letter_ok) begin
                           if (!held_valid_ff || held_dec_ff) begin
                              held_ff       <= letter_norm;
                              held_valid_ff <= 1'b1;
                              held_dec_ff   <= 1'b0;
                           end else begin
                              // A doubled letter is padded with X and stays waiting.
                              pair_a_ff   <= held_ff;
                              pair_b_ff   <= (held_ff == letter_norm) ? LTR_X : letter_norm;
                              pair_dec_ff <= 1'b0;
                              state_ff    <= ST_LOOK_A;
                              if (held_ff != letter_norm) begin
                                 held_valid_ff <= 1'b0;
                              end
                           end
                        end
                     end
                     CMD_DECRYPT: begin
                        if (letter_ok) begin
                           if (held_valid_ff && held_dec_ff) begin
                              pair_a_ff     <= held_ff;
                              pair_b_ff     <= letter_norm;
                              pair_dec_ff   <= 1'b1;
                              state_ff      <= ST_LOOK_A;
                              held_valid_ff <= 1'b0;
                              held_dec_ff   <= 1'b0;
                           end else begin
                              // A waiting plaintext letter is flushed with X first.
                              if (held_valid_ff) begin
                                 pair_a_ff   <= held_ff;
                                 pair_b_ff   <= LTR_X;
                                 pair_dec_ff <= 1'b0;
                                 state_ff    <= ST_LOOK_A;
                              end
                              held_ff       <= letter_norm;
                              held_valid_ff <= 1'b1;
                              held_dec_ff   <= 1'b1;
                           end
                        end
                     end
                     CMD_END: begin
                        if (held_valid_ff && !held_dec_ff) begin
                           pair_a_ff   <= held_ff;
                           pair_b_ff   <= LTR_X;
                           pair_dec_ff <= 1'b0;
                           state_ff    <= ST_LOOK_A;
                        end
                        held_valid_ff <= 1'b0;
                        held_dec_ff   <= 1'b0;
                     end
                     default: begin
                     end
                  endcase
               end
            end
            ST_FILL: begin
               sweep_ff <= 5'(sweep_ff + 5'd1);
               if (sweep_ff == LTR_MAX) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_LOOK_A: begin
               state_ff <= ST_LOOK_B;
            end
            ST_LOOK_B: begin
               cell_a_ff <= cell_rd_ff;
               state_ff  <= ST_CALC;
            end
            ST_CALC: begin
               addr_a_ff <= addr_a_in;
               addr_b_ff <= addr_b_in;
               state_ff  <= ST_READ_1;
            end
            ST_READ_1: begin
               state_ff <= ST_READ_2;
            end
            ST_READ_2: begin
               first_ff <= key_rd_ff;
               state_ff <= ST_EMIT_1;
            end
            ST_EMIT_1: begin
               if (rsp_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_letter_ff <= first_ff;
                  rsp_last_ff   <= 1'b0;
                  state_ff      <= ST_EMIT_2;
               end
            end
            ST_EMIT_2: begin
               // The key port still holds the second letter of the pair.
               if (rsp_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_letter_ff <= key_rd_ff;
                  rsp_last_ff   <= 1'b1;
                  state_ff      <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

@@ sv/pf_square.sv @@
// Key square store and reverse letter-to-cell store, one write and one registered read each.
module pf_square (
   input  logic                clock,
   input  pf_pkg::mem_req_type mem_req,
   output pf_pkg::cell_type    cell_rd_ff,
   output pf_pkg::letter_type  key_rd_ff
);
   import pf_pkg::*;

   letter_type key_square_ff [SQ_CELLS];
   cell_type   letter_cell_ff [NUM_LETTERS];

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         key_square_ff[mem_req.wr_cell]    <= mem_req.wr_letter;
         letter_cell_ff[mem_req.wr_letter] <= mem_req.wr_cell;
      end
      cell_rd_ff <= letter_cell_ff[mem_req.cell_rd_letter];
      key_rd_ff  <= key_square_ff[mem_req.key_rd_cell];
   end

endmodule

@@ sv/pf_pair_calc.sv @@
// Applies the row, column and rectangle rules to two cells to give the two output cells.
module pf_pair_calc (
   input  pf_pkg::cell_type cell_a,
   input  pf_pkg::cell_type cell_b,
   input  logic             dec,
   output pf_pkg::cell_type addr_a,
   output pf_pkg::cell_type addr_b
);
   import pf_pkg::*;

   coord_type r1, c1, r2, c2;

   always_comb begin
      r1 = cell_row(cell_a);
      c1 = cell_col(cell_a);
      r2 = cell_row(cell_b);
      c2 = cell_col(cell_b);
      if (r1 == r2) begin
         addr_a = cell_addr(r1, coord_step(c1, dec));
         addr_b = cell_addr(r2, coord_step(c2, dec));
      end else if (c1 == c2) begin
         addr_a = cell_addr(coord_step(r1, dec), c1);
         addr_b = cell_addr(coord_step(r2, dec), c2);
      end else begin
         addr_a = cell_addr(r1, c2);
         addr_b = cell_addr(r2, c1);
      end
   end

endmodule

@@ sv/pf_checker.sv @@
// Port-level checks on the Playfair digraph cipher, bound to its top level.
module pf_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic [2:0]         req_command,
   input pf_pkg::letter_type req_letter,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input pf_pkg::letter_type rsp_out_letter,
   input logic               rsp_last
);
   import pf_pkg::*;

   logic req_seen;
   assign req_seen = req_valid && (req_command <= 3'(CMD_END)) && (req_letter <= LTR_MAX);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_out_letter) && $stable(rsp_last)))
      else $error("result changed while stalled");

   a_pair_second: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_last) |=> (rsp_valid && rsp_last))
      else $error("second letter of a pair did not follow the first");

   a_busy_in_pair: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |-> !req_ready)
      else $error("command taken while a pair was half delivered");

   a_reset_empty: assert property (@(posedge clock)
      (reset || (req_seen && 1'b0)) |=> (!rsp_valid && req_ready))
      else $error("block not idle and empty after reset");

endmodule

bind playfair_digraph_cipher pf_checker u_pf_checker (.*);
